[rtl/core/length_prefix_deframer_macros.svh]
// ----------------------------------------------------------------------------
// Length-prefix deframer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIX_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIX_DEFRAMER_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define LPD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define LPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/lpd_pkg.sv]
// ----------------------------------------------------------------------------
// Length-prefix deframer package
// Shared constants, status codes and result types of the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lpd_pkg;

	// Default width of the payload byte counters.
	localparam int LPD_COUNT_BITS = 24;

	// Width of the length and limit fields.
	localparam int LPD_LEN_BITS = 24;

	// Reset value of the maximum frame length register.
	localparam logic [LPD_LEN_BITS-1:0] LPD_MAX_RESET = 24'd65535;

	// Status codes carried with each result item.
	typedef enum logic [1:0] {
		ST_PAYLOAD  = 2'd0,
		ST_ZERO_LEN = 2'd1,
		ST_OVERSIZE = 2'd2,
		ST_FAILED   = 2'd3
	} lpd_status_t;

	// One result item.
	typedef struct packed {
		logic [7:0]              out_byte;
		logic                    first_flag;
		logic                    last_flag;
		logic [LPD_LEN_BITS-1:0] frame_length;
		lpd_status_t             status;
	} lpd_result_t;

	// A result handed from the parser to the output buffer.
	typedef struct packed {
		logic        valid;
		lpd_result_t data;
	} lpd_push_t;

endpackage

`default_nettype wire

[rtl/core/lpd_byte_if.sv]
// ----------------------------------------------------------------------------
// Byte stream interface
// Valid/ready channel carrying one raw byte of the framed stream per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

[rtl/core/lpd_frame_if.sv]
// ----------------------------------------------------------------------------
// Deframed result interface
// Valid/ready channel carrying one payload byte or error report per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpd_frame_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        first_flag;
	logic        last_flag;
	logic [23:0] frame_length;
	logic [1:0]  status;

	modport source (
		output valid, output out_byte, output first_flag, output last_flag,
		output frame_length, output status, input ready
	);
	modport sink (
		input valid, input out_byte, input first_flag, input last_flag,
		input frame_length, input status, output ready
	);
endinterface

`default_nettype wire

[rtl/core/lpd_in_stage.sv]
// ----------------------------------------------------------------------------
// Deframer input register
// Holds one incoming byte until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_in_stage
	import lpd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [7:0] in_byte,
	output logic            in_ready,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	// The register takes a new item when empty or when its item moves on.
	assign in_ready = !valid_s1 || advance;

	// Valid bit is control state and resets; the byte does not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

`default_nettype wire

[rtl/core/lpd_parser.sv]
// ----------------------------------------------------------------------------
// Deframer parser
// Gathers the length header, checks it and tags payload bytes, or marks bytes
// failed after a bad header, one byte per cycle whenever advance is set.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_parser
	import lpd_pkg::*;
#(
	parameter int COUNT_BITS = LPD_COUNT_BITS
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    advance,
	input  wire logic [7:0]              byte_s1,
	input  wire logic [LPD_LEN_BITS-1:0] max_len,
	output lpd_push_t                    push
);

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_FAILED  = 2'd2
	} phase_t;

	// Largest length the counters can hold, one bit wider to cover 32 bits.
	localparam logic [32:0] COUNT_MASK = (33'd1 << COUNT_BITS) - 33'd1;
	localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

	phase_t                  phase_q, phase_d;
	logic [1:0]              hdr_cnt_q, hdr_cnt_d;
	logic [23:0]             hdr_low_q, hdr_low_d;
	logic [COUNT_BITS-1:0]   remain_q, remain_d;
	logic [COUNT_BITS-1:0]   cur_len_q, cur_len_d;
	logic [31:0]             declared;
	logic [31:0]             cur_wide;
	logic                    oversize;
	lpd_push_t               push_c;

	assign declared = {byte_s1, hdr_low_q};
	assign cur_wide = 32'(cur_len_q);
	assign oversize = ({1'b0, declared} > COUNT_MASK) ||
		(declared > {8'd0, max_len});

	// Next state and result for the byte held in the input register.
	always_comb begin
		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		hdr_low_d = hdr_low_q;
		remain_d  = remain_q;
		cur_len_d = cur_len_q;
		push_c    = '0;
		case (phase_q)
			PH_HEADER: begin
				if (hdr_cnt_q != 2'd3) begin
					case (hdr_cnt_q)
						2'd0: hdr_low_d[7:0] = hdr_low_q[7:0] | byte_s1;
						2'd1: hdr_low_d[15:8] = hdr_low_q[15:8] | byte_s1;
						2'd2: hdr_low_d[23:16] = hdr_low_q[23:16] | byte_s1;
						default: hdr_low_d = hdr_low_q;
					endcase
					hdr_cnt_d = hdr_cnt_q + 2'd1;
				end else begin
					hdr_cnt_d = 2'd0;
					hdr_low_d = '0;
					if (declared == 32'd0) begin
						phase_d = PH_FAILED;
						push_c.valid = 1'b1;
						push_c.data.status = ST_ZERO_LEN;
					end else if (oversize) begin
						// Report the declared length, saturated to 24 bits.
						phase_d = PH_FAILED;
						push_c.valid = 1'b1;
						push_c.data.status = ST_OVERSIZE;
						push_c.data.frame_length = (declared[31:24] != 8'd0) ?
							'1 : declared[23:0];
					end else begin
						phase_d   = PH_PAYLOAD;
						cur_len_d = declared[COUNT_BITS-1:0];
						remain_d  = declared[COUNT_BITS-1:0];
					end
				end
			end
			PH_PAYLOAD: begin
				push_c.valid             = 1'b1;
				push_c.data.out_byte     = byte_s1;
				push_c.data.first_flag   = (remain_q == cur_len_q);
				push_c.data.last_flag    = (remain_q <= CNT_ONE);
				push_c.data.frame_length = cur_wide[23:0];
				push_c.data.status       = ST_PAYLOAD;
				if (remain_q <= CNT_ONE) begin
					remain_d  = '0;
					phase_d   = PH_HEADER;
					hdr_cnt_d = 2'd0;
					hdr_low_d = '0;
				end else begin
					remain_d = remain_q - CNT_ONE;
				end
			end
			default: begin
				// Failed phase: every byte is dropped with a failed status.
				push_c.valid       = 1'b1;
				push_c.data.status = ST_FAILED;
			end
		endcase
	end

	// A result leaves only when the byte is actually consumed.
	always_comb begin
		push       = push_c;
		push.valid = push_c.valid && advance;
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_cnt_q <= 2'd0;
			hdr_low_q <= '0;
			remain_q  <= '0;
			cur_len_q <= '0;
		end else if (advance) begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			hdr_low_q <= hdr_low_d;
			remain_q  <= remain_d;
			cur_len_q <= cur_len_d;
		end
	end

endmodule

`default_nettype wire

[rtl/core/lpd_out_buf.sv]
// ----------------------------------------------------------------------------
// Deframer output buffer
// Two-entry result queue that decouples the parser from output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_out_buf
	import lpd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire lpd_push_t push,
	output logic           space,
	output logic           out_valid,
	input  wire logic      out_ready,
	output lpd_result_t    out_data
);

	lpd_result_t entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != 2'd0);
	assign out_data  = entry_q[rd_ptr_q];
	assign space     = (count_q != 2'd2);

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push.valid} - {1'b0, pop};
		end
	end

	// Result storage.
	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_ptr_q] <= push.data;
		end
	end

endmodule

`default_nettype wire

[rtl/core/length_prefix_deframer.sv]
// ----------------------------------------------------------------------------
// Length-prefix deframer
// Splits a byte stream of 4-byte little-endian length-prefixed frames.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle and sustains that rate
// indefinitely while the result side keeps up. Each byte is caught in an
// input register and parsed from there once the output buffer has room, and
// its result, if any, is written to that buffer, which feeds the frame
// channel. Header bytes give no result unless the completed length is zero,
// above max_frame_bytes or too large for the counters, in which case one
// error item is returned and every later byte comes back as a failed item
// until reset. A two-entry output buffer sits between parser and frame
// channel; in steady streaming it holds one result, so a stalled result
// cycle fills it and the stream side is held off until an entry drains, and
// longer stalls back-pressure the stream. max_frame_bytes is written through
// cfg_we/cfg_data and takes effect at the next frame header.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefix_deframer
	import lpd_pkg::*;
#(
	parameter int COUNT_BITS = LPD_COUNT_BITS
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [LPD_LEN_BITS-1:0] cfg_data,
	lpd_byte_if.sink                     stream,
	lpd_frame_if.source                  frame
);

	logic [LPD_LEN_BITS-1:0] max_len_q;
	logic                    valid_s1;
	logic [7:0]              byte_s1;
	logic                    space;
	logic                    advance;
	lpd_push_t               push;
	lpd_result_t             out_data;

	// Maximum frame length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= LPD_MAX_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_data;
		end
	end

	// A byte is parsed when it is held and the buffer has room for a result.
	assign advance = valid_s1 && space;

	lpd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (stream.valid),
		.in_byte  (stream.in_byte),
		.in_ready (stream.ready),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	lpd_parser #(
		.COUNT_BITS (COUNT_BITS)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.max_len (max_len_q),
		.push    (push)
	);

	lpd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space     (space),
		.out_valid (frame.valid),
		.out_ready (frame.ready),
		.out_data  (out_data)
	);

	// Result fields onto the frame channel.
	assign frame.out_byte     = out_data.out_byte;
	assign frame.first_flag   = out_data.first_flag;
	assign frame.last_flag    = out_data.last_flag;
	assign frame.frame_length = out_data.frame_length;
	assign frame.status       = out_data.status;

endmodule

`default_nettype wire

[rtl/core/lpd_checker.sv]
// ----------------------------------------------------------------------------
// Deframer port checker
// Checks result items seen on the top-level ports over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "length_prefix_deframer_macros.svh"

module lpd_checker
	import lpd_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  out_byte,
	input wire logic        first_flag,
	input wire logic        last_flag,
	input wire logic [23:0] frame_length,
	input wire logic [1:0]  status
);

	logic is_payload;

	assign is_payload = (status == ST_PAYLOAD);

	// A stalled result item stays offered.
	`LPD_ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid, "result item dropped while stalled")

	// Payload items always belong to a frame of nonzero length.
	`LPD_ASSERT_IMPL(a_payload_len, out_valid && is_payload, frame_length != 24'd0, "payload item with zero frame length")

	// Error and failed items carry no byte and no frame marks.
	`LPD_ASSERT_IMPL(a_error_clean, out_valid && !is_payload, out_byte == 8'd0 && !first_flag && !last_flag, "error item carries payload fields")

	// A byte that both opens and closes a frame implies a one-byte frame.
	`LPD_ASSERT_IMPL(a_single_byte, out_valid && is_payload && first_flag && last_flag, frame_length == 24'd1, "single-byte frame with wrong length")

endmodule

bind length_prefix_deframer lpd_checker u_lpd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (frame.valid),
	.out_ready    (frame.ready),
	.out_byte     (frame.out_byte),
	.first_flag   (frame.first_flag),
	.last_flag    (frame.last_flag),
	.frame_length (frame.frame_length),
	.status       (frame.status)
);

`default_nettype wire
